@@ src/sacvb_pkg.sv @@
// ----------------------------------------------------------------------------
// sacvb_pkg: shared types for the set-associative cache with victim buffer
// Request and response payloads, status codes and the front-to-back record.
// ----------------------------------------------------------------------------
package sacvb_pkg;

    localparam int ADDR_W = 32;
    localparam int WB_W   = 27;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_FILL_EMPTY = 3'd1,
        ST_VICTIM_HIT = 3'd2,
        ST_EVICT_FREE = 3'd3,
        ST_EVICT_LRU  = 3'd4,
        ST_EVICT_NOVB = 3'd5
    } status_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]      status;
        logic            writeback;
        logic [WB_W-1:0] writeback_block;
    } rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } bk_state_t;

endpackage

@@ src/sacvb_front.sv @@
// ----------------------------------------------------------------------------
// sacvb_front: request intake queue
// Two-entry queue that accepts requests and decouples the intake handshake
// from the back end that carries them out.
// ----------------------------------------------------------------------------
module sacvb_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sacvb_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output sacvb_pkg::req_t out_req
);
    import sacvb_pkg::*;

    req_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_req;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ src/sacvb_back.sv @@
// ----------------------------------------------------------------------------
// sacvb_back: tag lookup and update engine
// Reads one set from the tag memory, resolves hit, victim hit or eviction,
// writes the set back and registers the response.
// ----------------------------------------------------------------------------
module sacvb_back #(
    parameter int SETS          = 64,
    parameter int WAYS          = 4,
    parameter int OFFSET_BITS   = 5,
    parameter int VICTIM_BLOCKS = 8,
    parameter int ADDR_BITS     = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            victim_enable,
    input  logic            in_valid,
    output logic            in_ready,
    input  sacvb_pkg::req_t in_req,
    output logic            m_valid,
    input  logic            m_ready,
    output sacvb_pkg::rsp_t m_rsp
);
    import sacvb_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SB    = $clog2(SETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VB_W  = (VICTIM_BLOCKS > 1) ? $clog2(VICTIM_BLOCKS) : 1;
    localparam int BLK_W = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_W = BLK_W - SB;
    localparam int LW    = 1 + 1 + TAG_W + 32;

    typedef struct packed {
        logic             v;
        logic             d;
        logic [TAG_W-1:0] tag;
        logic [31:0]      stamp;
    } line_t;

    // Tag memory, one row per set; valid bits kept apart in flops
    logic [WAYS*LW-1:0] mem [SETS];
    logic [WAYS-1:0]    vld_reg [SETS];
    logic [WAYS*LW-1:0] row_reg;

    logic             vv_reg [VICTIM_BLOCKS];
    logic             vd_reg [VICTIM_BLOCKS];
    logic [BLK_W-1:0] vb_reg [VICTIM_BLOCKS];
    logic [31:0]      vs_reg [VICTIM_BLOCKS];

    logic [31:0]      cnt_reg;
    bk_state_t        st_reg, st_next;
    req_t             req_reg;
    logic             mv_reg;
    rsp_t             rsp_reg;

    logic [BLK_W-1:0] blk;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic [31:0]      now;

    assign blk     = req_reg.address[ADDR_BITS-1:OFFSET_BITS];
    assign set_idx = (SETS > 1) ? SET_W'(blk) : '0;
    assign tag     = blk[BLK_W-1:SB];
    assign now     = cnt_reg + 32'd1;

    line_t            ln [WAYS];
    line_t            nl [WAYS];
    logic             hit;
    logic [WAY_W-1:0] hw, pw;
    logic             vhit;
    logic [VB_W-1:0]  vh, pv;
    logic             do_exec;
    rsp_t             r;
    logic             vwr;
    logic [VB_W-1:0]  vidx;
    logic             vnv, vnd;
    logic [BLK_W-1:0] vnb;
    logic [BLK_W-1:0] ob;

    always_comb begin
        logic found;
        for (int w = 0; w < WAYS; w++) begin
            ln[w]   = row_reg[w*LW +: LW];
            ln[w].v = vld_reg[set_idx][w];
        end
        hit = 1'b0; hw = '0;
        for (int w = 0; w < WAYS; w++)
            if (!hit && ln[w].v && ln[w].tag == tag) begin
                hit = 1'b1; hw = WAY_W'(w);
            end
        found = 1'b0; pw = '0;
        for (int w = 0; w < WAYS; w++)
            if (!found && !ln[w].v) begin
                found = 1'b1; pw = WAY_W'(w);
            end
        if (!found)
            for (int w = 1; w < WAYS; w++)
                if (ln[w].stamp < ln[pw].stamp) pw = WAY_W'(w);
        vhit = 1'b0; vh = '0;
        for (int v = 0; v < VICTIM_BLOCKS; v++)
            if (!vhit && vv_reg[v] && vb_reg[v] == blk) begin
                vhit = 1'b1; vh = VB_W'(v);
            end
        vhit = vhit && victim_enable;
        found = 1'b0; pv = '0;
        for (int v = 0; v < VICTIM_BLOCKS; v++)
            if (!found && !vv_reg[v]) begin
                found = 1'b1; pv = VB_W'(v);
            end
        if (!found)
            for (int v = 1; v < VICTIM_BLOCKS; v++)
                if (vs_reg[v] < vs_reg[pv]) pv = VB_W'(v);

        ob = BLK_W'({ln[pw].tag, set_idx});
        if (SETS == 1) ob = BLK_W'(ln[pw].tag);
        for (int w = 0; w < WAYS; w++) nl[w] = ln[w];
        r = '0; vwr = 1'b0; vidx = pv; vnv = 1'b1; vnd = 1'b0; vnb = ob;
        priority if (hit) begin
            nl[hw].stamp = now;
            nl[hw].d     = ln[hw].d | req_reg.op;
            r.status     = ST_HIT;
        end else if (vhit) begin
            nl[pw] = '{v: 1'b1, d: vd_reg[vh] | req_reg.op, tag: tag, stamp: now};
            vwr  = 1'b1; vidx = vh;
            vnv  = ln[pw].v;
            vnd  = ln[pw].v & ln[pw].d;
            vnb  = ln[pw].v ? ob : '0;
            r.status = ST_VICTIM_HIT;
        end else begin
            nl[pw] = '{v: 1'b1, d: req_reg.op, tag: tag, stamp: now};
            if (!ln[pw].v) begin
                r.status = ST_FILL_EMPTY;
            end else if (victim_enable) begin
                vwr = 1'b1; vnd = ln[pw].d;
                if (!vv_reg[pv]) begin
                    r.status = ST_EVICT_FREE;
                end else begin
                    r.status = ST_EVICT_LRU;
                    if (vd_reg[pv]) begin
                        r.writeback       = 1'b1;
                        r.writeback_block = WB_W'(vb_reg[pv]);
                    end
                end
            end else begin
                r.status = ST_EVICT_NOVB;
                if (ln[pw].d) begin
                    r.writeback       = 1'b1;
                    r.writeback_block = WB_W'(ob);
                end
            end
        end
    end

    assign do_exec  = (st_reg == BK_EXEC) && (!mv_reg || m_ready);
    assign in_ready = (st_reg == BK_IDLE);
    assign m_valid  = mv_reg;
    assign m_rsp    = rsp_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE: if (in_valid) st_next = BK_READ;
            BK_READ: st_next = BK_EXEC;
            BK_EXEC: if (do_exec) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) req_reg <= in_req;
        if (st_reg == BK_READ) row_reg <= mem[set_idx];
        if (do_exec) begin
            for (int w = 0; w < WAYS; w++) mem[set_idx][w*LW +: LW] <= nl[w];
            rsp_reg <= r;
            if (vwr) begin
                vb_reg[vidx] <= vnb;
                vs_reg[vidx] <= now;
            end
        end
        if (!aresetn) begin
            st_reg  <= BK_IDLE;
            mv_reg  <= 1'b0;
            cnt_reg <= '0;
            for (int s = 0; s < SETS; s++) vld_reg[s] <= '0;
            for (int v = 0; v < VICTIM_BLOCKS; v++) begin
                vv_reg[v] <= 1'b0;
                vd_reg[v] <= 1'b0;
            end
        end else begin
            st_reg <= st_next;
            if (m_ready) mv_reg <= 1'b0;
            if (do_exec) begin
                mv_reg  <= 1'b1;
                cnt_reg <= now;
                for (int w = 0; w < WAYS; w++) vld_reg[set_idx][w] <= nl[w].v;
                if (vwr) begin
                    vv_reg[vidx] <= vnv;
                    vd_reg[vidx] <= vnd;
                end
            end
        end
    end

endmodule

@@ src/set_assoc_cache_with_victim_buffer_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_with_victim_buffer_top: cache tag engine with victim buffer
// Tag state of a write-back, write-allocate LRU cache plus victim buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_req transfer one access (op, address). m_valid/m_ready
//   /m_rsp transfer one result (status, writeback, writeback_block) per
//   access, in order. cfg_valid/cfg_ready/cfg_data write victim_enable;
//   write it only while the block is idle.
//   A two-entry intake queue feeds the back end, so requests are taken while
//   the back end works. The back end handles each access in order: latch,
//   tag memory read (the set row), then compare/update and tag write; it
//   takes no new access until the last one is done.
//   Reset clears all line and victim valid bits, the access counter and
//   sets victim_enable to 1; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register and
//   the back end holds its next finished access; the queue then fills and
//   s_ready drops.
// ----------------------------------------------------------------------------
module set_assoc_cache_with_victim_buffer_top #(
    parameter int SETS          = 64,
    parameter int WAYS          = 4,
    parameter int OFFSET_BITS   = 5,
    parameter int VICTIM_BLOCKS = 8,
    parameter int ADDR_BITS     = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sacvb_pkg::req_t s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output sacvb_pkg::rsp_t m_rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);
    import sacvb_pkg::*;

    logic venable_reg;
    logic q_valid, q_ready;
    req_t q_req, q_req_m;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            venable_reg <= 1'b1;
        end else if (cfg_valid) begin
            venable_reg <= cfg_data;
        end
    end

    sacvb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (s_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    // Drop address bits above ADDR_BITS
    always_comb begin
        q_req_m = q_req;
        for (int i = 0; i < ADDR_W; i++)
            if (i >= ADDR_BITS) q_req_m.address[i] = 1'b0;
    end

    sacvb_back #(
        .SETS          (SETS),
        .WAYS          (WAYS),
        .OFFSET_BITS   (OFFSET_BITS),
        .VICTIM_BLOCKS (VICTIM_BLOCKS),
        .ADDR_BITS     (ADDR_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .victim_enable (venable_reg),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_req        (q_req_m),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rsp         (m_rsp)
    );

endmodule

@@ verif/tb_set_assoc_cache_with_victim_buffer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_with_victim_buffer_top: self-checking bench for the cache
// Drives read/write accesses through the valid/ready request channel, keeps a
// shadow copy of the tag, LRU and victim state, and compares every response
// field against the shadow prediction. The victim buffer is toggled between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_with_victim_buffer_top;
    import sacvb_pkg::*;

    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int OFF_BITS = 5;
    localparam int VB_SLOTS = 8;
    localparam int LINES    = SETS * WAYS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1000;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    always #2 aclk = ~aclk;

    set_assoc_cache_with_victim_buffer_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // shadow tag state
    bit          sh_valid [LINES];
    bit          sh_dirty [LINES];
    bit [20:0]   sh_tag   [LINES];
    bit [31:0]   sh_stamp [LINES];
    bit          vb_valid [VB_SLOTS];
    bit          vb_dirty [VB_SLOTS];
    bit [26:0]   vb_block [VB_SLOTS];
    bit [31:0]   vb_stamp [VB_SLOTS];
    bit [31:0]   access_cnt;
    bit          vb_enable;

    rsp_t pending_rsp[$];
    int   mismatches;
    int   rsp_seen;
    int   status_hits[6];
    bit   rx_idle_en = 1'b1;
    bit   tx_idle_en = 1'b1;
    bit   rx_hold_req;
    longint cycles;

    function automatic int choose_way(int base);
        int best = 0;
        for (int w = 0; w < WAYS; w++)
            if (!sh_valid[base + w]) return w;
        for (int w = 1; w < WAYS; w++)
            if (sh_stamp[base + w] < sh_stamp[base + best]) best = w;
        return best;
    endfunction

    function automatic int choose_slot();
        int best = 0;
        for (int v = 0; v < VB_SLOTS; v++)
            if (!vb_valid[v]) return v;
        for (int v = 1; v < VB_SLOTS; v++)
            if (vb_stamp[v] < vb_stamp[best]) best = v;
        return best;
    endfunction

    // Apply one access to the shadow state and return its response.
    function automatic rsp_t cache_access(req_t rq);
        rsp_t      r = '0;
        bit [26:0] blk = rq.address[31:OFF_BITS];
        int        set_i = blk % SETS;
        bit [20:0] tag = 21'(blk / SETS);
        int        base = set_i * WAYS;
        int        i, v;
        bit        ov, od;
        bit [26:0] ob;
        bit [31:0] now;
        access_cnt = access_cnt + 1;
        now = access_cnt;
        for (int w = 0; w < WAYS; w++) begin
            if (sh_valid[base + w] && sh_tag[base + w] == tag) begin
                sh_stamp[base + w] = now;
                if (rq.op == OP_WRITE) sh_dirty[base + w] = 1'b1;
                r.status = ST_HIT;
                return r;
            end
        end
        if (vb_enable) begin
            for (int s = 0; s < VB_SLOTS; s++) begin
                if (vb_valid[s] && vb_block[s] == blk) begin
                    i = base + choose_way(base);
                    ov = sh_valid[i];
                    od = sh_dirty[i];
                    ob = {sh_tag[i], 6'(set_i)};
                    sh_valid[i] = 1'b1;
                    sh_dirty[i] = vb_dirty[s] | (rq.op == OP_WRITE);
                    sh_tag[i] = tag;
                    sh_stamp[i] = now;
                    vb_valid[s] = ov;
                    vb_dirty[s] = ov ? od : 1'b0;
                    vb_block[s] = ov ? ob : '0;
                    vb_stamp[s] = now;
                    r.status = ST_VICTIM_HIT;
                    return r;
                end
            end
        end
        i = base + choose_way(base);
        if (!sh_valid[i]) begin
            r.status = ST_FILL_EMPTY;
        end else begin
            ob = {sh_tag[i], 6'(set_i)};
            od = sh_dirty[i];
            if (vb_enable) begin
                v = choose_slot();
                if (!vb_valid[v]) begin
                    r.status = ST_EVICT_FREE;
                end else begin
                    r.status = ST_EVICT_LRU;
                    if (vb_dirty[v]) begin
                        r.writeback = 1'b1;
                        r.writeback_block = vb_block[v];
                    end
                end
                vb_valid[v] = 1'b1;
                vb_dirty[v] = od;
                vb_block[v] = ob;
                vb_stamp[v] = now;
            end else begin
                r.status = ST_EVICT_NOVB;
                if (od) begin
                    r.writeback = 1'b1;
                    r.writeback_block = ob;
                end
            end
        end
        sh_valid[i] = 1'b1;
        sh_dirty[i] = (rq.op == OP_WRITE);
        sh_tag[i] = tag;
        sh_stamp[i] = now;
        return r;
    endfunction

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still pending",
                     cycles, pending_rsp.size());
            $display("tb_set_assoc_cache_with_victim_buffer_top: errors");
            $finish;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    int hold_left;
    bit hold_done;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_hold_req && !hold_done) begin
            hold_left <= 60;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= rx_idle_en ? ($urandom_range(99) >= 18) : 1'b1;
        end
    end

    // Response checker: compare each transfer with the oldest prediction.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", m_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (m_rsp.status <= 5) status_hits[m_rsp.status]++;
                if (m_rsp.status !== want.status || m_rsp.writeback !== want.writeback
                    || m_rsp.writeback_block !== want.writeback_block) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"response %0d: expected st=%0d wb=%0d blk=%h,",
                                  " got st=%0d wb=%0d blk=%h"},
                                 rsp_seen, want.status, want.writeback,
                                 want.writeback_block, m_rsp.status,
                                 m_rsp.writeback, m_rsp.writeback_block);
                end
            end
        end
    end

    // Offer one access and wait for its transfer; predict at acceptance.
    // Valid stays high after the transfer so the next offer can follow
    // back to back; drop it while idling.
    task automatic send_access(logic op, logic [31:0] addr);
        req_t rq;
        rq.op = op;
        rq.address = addr;
        while (tx_idle_en && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.push_back(cache_access(rq));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_victim_enable(bit en);
        cfg_valid <= 1'b1;
        cfg_data <= en;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        vb_enable = en;
    endtask

    // Build an address from a set and tag, with a random offset.
    function automatic logic [31:0] make_addr(int set_i, int tag);
        return {21'(tag), 6'(set_i), 5'($urandom_range(31))};
    endfunction

    typedef struct {
        logic        op;
        logic [31:0] addr;
        bit          known;
        logic [2:0]  st;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{OP_READ,  32'h0000_0000, 1, ST_FILL_EMPTY},
        '{OP_WRITE, 32'h0000_001F, 1, ST_HIT},
        '{OP_WRITE, 32'hFFFF_FFFF, 1, ST_FILL_EMPTY},
        '{OP_READ,  32'hFFFF_FFE0, 1, ST_HIT},
        // fill set 0 with ways then overflow into the victim buffer
        '{OP_WRITE, 32'h0000_0800, 1, ST_FILL_EMPTY},
        '{OP_READ,  32'h0000_1000, 1, ST_FILL_EMPTY},
        '{OP_READ,  32'h0000_1800, 1, ST_FILL_EMPTY},
        '{OP_READ,  32'h0000_2000, 1, ST_EVICT_FREE},
        // the dirty block moved to the victim buffer: swap it back
        '{OP_READ,  32'h0000_0000, 1, ST_VICTIM_HIT},
        '{OP_WRITE, 32'h0000_0800, 0, 0},
        '{OP_READ,  32'hAAAA_AAAA, 0, 0},
        '{OP_WRITE, 32'h5555_5555, 0, 0}
    };

    initial begin
        bit [31:0] tag_pool[8];
        int sent;
        vb_enable = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed[k]) begin
            send_access(directed[k].op, directed[k].addr);
            if (directed[k].known && pending_rsp[$].status !== directed[k].st) begin
                mismatches++;
                $display("directed row %0d: predictor gives %0d, table says %0d",
                         k, pending_rsp[$].status, directed[k].st);
            end
        end
        drain();

        // Random phases: victim enable is off in phases 1 and 4, on in the rest; small tag pools per phase
        // keep sets crowded so every status and write-back path is hit.
        for (int ph = 0; ph < 6; ph++) begin
            write_victim_enable(ph % 3 != 1);
            foreach (tag_pool[t]) tag_pool[t] = $urandom();
            rx_idle_en = (ph != 2);
            tx_idle_en = (ph != 2);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (ph == 3 && n == 20) rx_hold_req = 1'b1;
                if (ph == 3 && n == 22) rx_hold_req = 1'b0;
                if (n == 80) drain();
                if ($urandom_range(9) == 0)
                    send_access(1'($urandom_range(1)), $urandom());
                else
                    send_access(1'($urandom_range(1)),
                                make_addr($urandom_range(3) == 0 ? $urandom_range(63)
                                                                 : $urandom_range(1),
                                          tag_pool[$urandom_range(ph < 3 ? 7 : 5)]));
            end
            drain();
        end
        write_victim_enable(1'b1);
        repeat (10) @(posedge aclk);

        $display("checked %0d responses: hit %0d fill %0d vhit %0d free %0d vlru %0d novb %0d",
                 rsp_seen, status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4], status_hits[5]);
        $display("victim buffer toggled on and off across 6 phases, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("tb_set_assoc_cache_with_victim_buffer_top: clean");
        else
            $display("tb_set_assoc_cache_with_victim_buffer_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/sacvb_pkg.sv
src/sacvb_front.sv
src/sacvb_back.sv
src/set_assoc_cache_with_victim_buffer_top.sv
verif/tb_set_assoc_cache_with_victim_buffer_top.sv
